// ----- hdl/lcgre_pkg.sv -----
// ----------------------------------------------------------------------------
// LCG random request engine package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package lcgre_pkg;

  localparam logic [63:0] LCG_MUL = 64'd2862933555777941757;
  localparam logic [63:0] LCG_ADD = 64'd3037000493;
  localparam logic [31:0] MUL_LO  = LCG_MUL[31:0];
  localparam logic [31:0] MUL_HI  = LCG_MUL[63:32];

  localparam int unsigned BUCKET_BITS = 32;
  localparam int unsigned FILL_W      = $clog2(BUCKET_BITS + 1);
  localparam int unsigned DIV_BITS    = 31;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_BITS);
  localparam int unsigned SPAN_W      = 33;
  localparam int unsigned MUL_STEPS   = 3;
  localparam int unsigned MSTEP_W     = $clog2(MUL_STEPS);

  typedef enum logic [2:0] {
    KIND_WORD32 = 3'd0,
    KIND_BIT    = 3'd1,
    KIND_WORD64 = 3'd2,
    KIND_RANGE  = 3'd3,
    KIND_DICE   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_TAKE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic seed_we;
    logic mul_step;
    logic cap_word;
    logic refill;
    logic div_load;
    logic div_step;
    logic take_bit;
    logic set_err;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  range_bad;
    logic  dice_bad;
    logic  count_zero;
    logic  count_last;
    logic  fill_zero;
    logic  mul_last;
    logic  div_last;
    logic  out_free;
  } stat_t;

endpackage

// ----- hdl/lcgre_ctrl.sv -----
// ----------------------------------------------------------------------------
// LCG random request engine controller
// Sequences generator steps, remainder passes and result delivery per request.
// ----------------------------------------------------------------------------
module lcgre_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  lcgre_pkg::stat_t stat_i,
  output lcgre_pkg::cmd_t  cmd_o
);
  import lcgre_pkg::*;

  state_e state_q, state_d;
  logic   second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cfg_ready_o    = 1'b1;
        cmd_o.seed_we  = cfg_valid_i;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          second_d   = 1'b0;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.kind)
          KIND_WORD32, KIND_WORD64: state_d = ST_MUL;
          KIND_BIT:   state_d = stat_i.fill_zero ? ST_MUL : ST_TAKE;
          KIND_RANGE: begin
            if (stat_i.range_bad) begin
              cmd_o.set_err = 1'b1;
              state_d       = ST_FIN;
            end else begin
              state_d = ST_MUL;
            end
          end
          KIND_DICE: begin
            if (stat_i.dice_bad) begin
              cmd_o.set_err = 1'b1;
              state_d       = ST_FIN;
            end else if (stat_i.count_zero) begin
              state_d = ST_FIN;
            end else begin
              state_d = ST_MUL;
            end
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.cap_word = stat_i.kind inside {KIND_WORD32, KIND_WORD64};
        cmd_o.refill   = (stat_i.kind == KIND_BIT);
        cmd_o.div_load = stat_i.kind inside {KIND_RANGE, KIND_DICE};
        if (stat_i.mul_last) begin
          case (stat_i.kind)
            KIND_WORD64: begin
              if (second_q) begin
                state_d = ST_FIN;
              end else begin
                second_d = 1'b1;
              end
            end
            KIND_BIT:               state_d = ST_TAKE;
            KIND_RANGE, KIND_DICE:  state_d = ST_DIV;
            default:                state_d = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          if (stat_i.kind == KIND_DICE && !stat_i.count_last) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_TAKE: begin
        cmd_o.take_bit = 1'b1;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/lcgre_dp.sv -----
// ----------------------------------------------------------------------------
// LCG random request engine datapath
// Generator state, shared 32x32 multiplier, restoring remainder unit, bit
// bucket, result accumulator and output register.
// ----------------------------------------------------------------------------
module lcgre_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcgre_pkg::cmd_t    cmd_i,
  output lcgre_pkg::stat_t   stat_o,
  input  logic [63:0]        seed_i,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic [7:0]         dice_count_i,
  input  logic [15:0]        dice_max_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        word_out_o,
  output logic signed [31:0] int_out_o,
  output logic               status_o
);
  import lcgre_pkg::*;

  logic [63:0]          gen_q;
  logic [31:0]          bucket_q;
  logic [FILL_W-1:0]    fill_q;
  logic [MSTEP_W-1:0]   mstep_q;
  logic [63:0]          acc_q, acc_d;
  kind_e                kind_q;
  logic signed [31:0]   low_q;
  logic [SPAN_W-1:0]    span_q, span_d;
  logic [7:0]           count_q;
  logic                 range_bad_q;
  logic                 dice_bad_q;
  logic [63:0]          word_q;
  logic [31:0]          int_q;
  logic                 status_q;
  logic [DIV_BITS-1:0]  dvd_q;
  logic [31:0]          rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 out_valid_q;
  logic [63:0]          out_word_q;
  logic [31:0]          out_int_q;
  logic                 out_status_q;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic              mul_last;
  logic              div_last;
  logic [SPAN_W-1:0] trial;
  logic [SPAN_W-1:0] rem_d;
  logic [31:0]       offset;
  logic              out_free;

  // The low 64 bits of the product need the low-by-low term and the low
  // halves of both cross terms, one per pass of the shared multiplier.
  always_comb begin
    case (mstep_q)
      MSTEP_W'(0): begin
        mul_a = gen_q[31:0];
        mul_b = MUL_LO;
      end
      MSTEP_W'(1): begin
        mul_a = gen_q[63:32];
        mul_b = MUL_LO;
      end
      default: begin
        mul_a = gen_q[31:0];
        mul_b = MUL_HI;
      end
    endcase
  end

  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign mul_last = (mstep_q == MSTEP_W'(MUL_STEPS - 1));

  always_comb begin
    if (mstep_q == MSTEP_W'(0)) begin
      acc_d = prod + LCG_ADD;
    end else begin
      acc_d = acc_q + {prod[31:0], 32'd0};
    end
  end

  assign trial    = {rem_q, dvd_q[DIV_BITS-1]};
  assign rem_d    = (trial >= span_q) ? (trial - span_q) : trial;
  assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_BITS - 1));
  assign offset   = (kind_q == KIND_RANGE) ? low_q : 32'd1;

  always_comb begin
    if (kind_e'(kind_i) == KIND_RANGE) begin
      span_d = {range_high_i[31], range_high_i} - {range_low_i[31], range_low_i}
               + SPAN_W'(1);
    end else begin
      span_d = {{(SPAN_W - 16){1'b0}}, dice_max_i};
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q       <= '0;
      bucket_q    <= '0;
      fill_q      <= '0;
      mstep_q     <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.seed_we) begin
        gen_q    <= seed_i;
        bucket_q <= '0;
        fill_q   <= '0;
      end
      if (cmd_i.mul_step) begin
        mstep_q <= mul_last ? '0 : mstep_q + MSTEP_W'(1);
        if (mul_last) begin
          gen_q <= acc_d;
          if (cmd_i.refill) begin
            bucket_q <= acc_d[63:32];
            fill_q   <= FILL_W'(BUCKET_BITS);
          end
          if (cmd_i.div_load) begin
            div_cnt_q <= '0;
          end
        end
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.take_bit) begin
        bucket_q <= {1'b0, bucket_q[31:1]};
        fill_q   <= fill_q - FILL_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= kind_e'(kind_i);
      low_q       <= range_low_i;
      span_q      <= span_d;
      count_q     <= dice_count_i;
      range_bad_q <= (range_high_i < range_low_i);
      dice_bad_q  <= (dice_max_i == 16'd0);
      word_q      <= '0;
      int_q       <= '0;
      status_q    <= 1'b0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_d;
      if (mul_last && cmd_i.cap_word) begin
        word_q <= {word_q[31:0], acc_d[63:32]};
      end
      if (mul_last && cmd_i.div_load) begin
        dvd_q <= acc_d[62:32];
        rem_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
      rem_q <= rem_d[31:0];
      if (div_last) begin
        int_q   <= int_q + offset + rem_d[31:0];
        count_q <= count_q - 8'd1;
      end
    end
    if (cmd_i.take_bit) begin
      word_q <= {63'd0, bucket_q[0]};
    end
    if (cmd_i.set_err) begin
      status_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_word_q   <= word_q;
      out_int_q    <= int_q;
      out_status_q <= status_q;
    end
  end

  assign stat_o.kind       = kind_q;
  assign stat_o.range_bad  = range_bad_q;
  assign stat_o.dice_bad   = dice_bad_q;
  assign stat_o.count_zero = (count_q == 8'd0);
  assign stat_o.count_last = (count_q == 8'd1);
  assign stat_o.fill_zero  = (fill_q == '0);
  assign stat_o.mul_last   = mul_last;
  assign stat_o.div_last   = div_last;
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign word_out_o  = out_word_q;
  assign int_out_o   = out_int_q;
  assign status_o    = out_status_q;

endmodule

// ----- hdl/lcg_random_request_engine_core.sv -----
// ----------------------------------------------------------------------------
// LCG random request engine
// Each request is served by a 64-bit linear congruential generator whose step
// runs as three passes of one shared 32x32 multiplier, and range and dice draws
// reduce each word through a restoring remainder unit at one bit per cycle
// over 31 dividend bits. A finished result sits in an output register, so the
// next request is taken while it waits. A seed write is accepted only while no
// request is in progress.
// ----------------------------------------------------------------------------
module lcg_random_request_engine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [63:0]        seed_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic [7:0]         dice_count_i,
  input  logic [15:0]        dice_max_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        word_out_o,
  output logic signed [31:0] int_out_o,
  output logic               status_o
);
  import lcgre_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lcgre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lcgre_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .seed_i       (seed_i),
    .kind_i       (kind_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .dice_count_i (dice_count_i),
    .dice_max_i   (dice_max_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_out_o   (word_out_o),
    .int_out_o    (int_out_o),
    .status_o     (status_o)
  );

endmodule
